FILE: design/assert_macros.svh
// Assertion helpers used by the parse core module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant violated");

// Antecedent at one edge forces the consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/oscp_pkg.sv
`default_nettype none

package oscp_pkg;

    localparam int unsigned MAX_PIV_BYTES = 5;
    localparam int unsigned TAIL_W        = 10;

    localparam logic [7:0] FLAG_EXT_MASK = 8'he0;
    localparam logic [7:0] FLAG_PIV_MASK = 8'h07;
    localparam logic [7:0] FLAG_H_MASK   = 8'h10;
    localparam logic [7:0] FLAG_K_MASK   = 8'h08;

    typedef enum logic [2:0] {
        ROLE_FLAGS   = 3'd0,
        ROLE_PIV     = 3'd1,
        ROLE_CTX_LEN = 3'd2,
        ROLE_CTX     = 3'd3,
        ROLE_KID     = 3'd4,
        ROLE_EXCESS  = 3'd5,
        ROLE_NONE    = 3'd6
    } byte_role_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_EXT_BITS     = 3'd1,
        ERR_PIV_LEN      = 3'd2,
        ERR_NO_CTX_LEN   = 3'd3,
        ERR_LEN_MISMATCH = 3'd4,
        ERR_TOO_LONG     = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       is_last;
        logic       is_empty;
    } in_item_t;

    typedef struct packed {
        byte_role_t byte_role;
        logic [7:0] field_index;
        logic       done_res;
        logic       valid_res;
        err_t       error_code;
        logic [2:0] piv_len;
        logic       has_kid_context;
        logic [7:0] kctx_len;
        logic       has_kid;
        logic [7:0] kid_len;
    } result_t;

endpackage

`default_nettype wire

FILE: design/oscp_input_stage.sv
`default_nettype none

module oscp_input_stage
    import oscp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire in_item_t s_item,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/oscp_parse_core.sv
`default_nettype none
`include "assert_macros.svh"

module oscp_parse_core
    import oscp_pkg::*;
#(
    parameter int unsigned MAX_OPTION_BYTES = 255,
    parameter int unsigned POS_W            = 8
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_item_t item,
    output result_t       result
);

    localparam int unsigned CW = ((POS_W > TAIL_W) ? POS_W : TAIL_W) + 1;

    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [4:0]        flags_reg, flags_next;
    logic [7:0]        ctx_reg,   ctx_next;
    logic [TAIL_W-1:0] tail_reg,  tail_next;
    err_t              pend_reg,  pend_next;

    logic [7:0]  b;
    logic        first;
    logic [2:0]  n_cur;
    logic        h_cur;
    logic        k_cur;
    logic [CW-1:0] p_x, n1, n2, tail_cur, tail_upd, max_x, len, diff, idx_x;
    logic [7:0]  ctx_upd;
    err_t        pend_cur;
    err_t        err;
    byte_role_t  role;
    logic        done_now;
    logic        state_idle;

    assign b        = item.option_byte;
    assign first    = (pos_reg == '0);
    assign n_cur    = first ? b[2:0] : flags_reg[2:0];
    assign h_cur    = first ? ((b & FLAG_H_MASK) != 8'h00) : flags_reg[3];
    assign k_cur    = first ? ((b & FLAG_K_MASK) != 8'h00) : flags_reg[4];
    assign p_x      = CW'(pos_reg);
    assign n1       = CW'(n_cur) + CW'(1);
    assign n2       = n1 + CW'(1);
    assign tail_cur = first ? n1 : CW'(tail_reg);
    assign max_x    = CW'(MAX_OPTION_BYTES);
    assign len      = p_x + CW'(1);

    always_comb begin
        pend_cur = pend_reg;
        if (first) begin
            if ((b & FLAG_EXT_MASK) != 8'h00) begin
                pend_cur = ERR_EXT_BITS;
            end else if (n_cur > 3'(MAX_PIV_BYTES)) begin
                pend_cur = ERR_PIV_LEN;
            end else begin
                pend_cur = ERR_NONE;
            end
        end
    end

    always_comb begin
        role     = ROLE_EXCESS;
        idx_x    = '0;
        ctx_upd  = first ? 8'h00 : ctx_reg;
        tail_upd = tail_cur;
        priority if (first) begin
            role = ROLE_FLAGS;
        end else if (p_x >= max_x) begin
            role = ROLE_EXCESS;
        end else if (p_x < n1) begin
            role  = ROLE_PIV;
            idx_x = p_x - CW'(1);
        end else if (h_cur && p_x == n1) begin
            role     = ROLE_CTX_LEN;
            ctx_upd  = b;
            tail_upd = n2 + CW'(b);
        end else if (h_cur && p_x < tail_cur) begin
            role  = ROLE_CTX;
            idx_x = p_x - n2;
        end else begin
            role  = k_cur ? ROLE_KID : ROLE_EXCESS;
            idx_x = p_x - tail_cur;
        end
    end

    always_comb begin
        err  = ERR_NONE;
        diff = len - tail_upd;
        priority if (pend_cur != ERR_NONE) begin
            err = pend_cur;
        end else if (len > max_x) begin
            err = ERR_TOO_LONG;
        end else if (h_cur && n1 >= len) begin
            err = ERR_NO_CTX_LEN;
        end else if (k_cur) begin
            if (tail_upd > len) begin
                err = ERR_LEN_MISMATCH;
            end
        end else if (tail_upd != len) begin
            err = ERR_LEN_MISMATCH;
        end
    end

    always_comb begin
        result = '0;
        if (item.is_empty) begin
            result.byte_role  = ROLE_NONE;
            result.done_res   = 1'b1;
            result.valid_res  = 1'b1;
            result.error_code = ERR_NONE;
        end else begin
            result.byte_role       = role;
            result.field_index     = idx_x[7:0];
            result.piv_len         = n_cur;
            result.has_kid_context = h_cur;
            result.kctx_len        = h_cur ? ctx_upd : 8'h00;
            result.has_kid         = k_cur;
            result.error_code      = ERR_NONE;
            if (item.is_last) begin
                result.done_res   = 1'b1;
                result.valid_res  = (err == ERR_NONE);
                result.error_code = err;
                if (err == ERR_NONE && k_cur) begin
                    result.kid_len = (diff > CW'(255)) ? 8'hff : diff[7:0];
                end
            end
        end
    end

    always_comb begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        ctx_next   = ctx_reg;
        tail_next  = tail_reg;
        pend_next  = pend_reg;
        if (advance) begin
            if (item.is_empty || item.is_last) begin
                pos_next   = '0;
                flags_next = '0;
                ctx_next   = '0;
                tail_next  = '0;
                pend_next  = ERR_NONE;
            end else begin
                if (p_x < max_x) begin
                    pos_next = pos_reg + POS_W'(1);
                end
                flags_next = {k_cur, h_cur, n_cur};
                ctx_next   = ctx_upd;
                tail_next  = tail_upd[TAIL_W-1:0];
                pend_next  = pend_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            flags_reg <= '0;
            ctx_reg   <= '0;
            tail_reg  <= '0;
            pend_reg  <= ERR_NONE;
        end else begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            ctx_reg   <= ctx_next;
            tail_reg  <= tail_next;
            pend_reg  <= pend_next;
        end
    end

    assign done_now   = advance && (item.is_last || item.is_empty);
    assign state_idle = (pos_reg == '0) && (pend_reg == ERR_NONE) && (flags_reg == '0);

    `ASSERT_ALWAYS(a_pos_bound, aclk, aresetn, CW'(pos_reg) <= max_x)
    `ASSERT_ALWAYS(a_pend_after_flags, aclk, aresetn, (pend_reg == ERR_NONE) || (pos_reg != '0))
    `ASSERT_NEXT(a_clear_on_done, aclk, aresetn, done_now, state_idle)

endmodule

`default_nettype wire

FILE: design/oscp_output_stage.sv
`default_nettype none

module oscp_output_stage
    import oscp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t result,
    input  wire logic    m_tready,
    output logic         m_tvalid,
    output logic         slot_free,
    output result_t      result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: design/oscore_option_parser.sv
// Channel  Dir  Ports                       Content
// s_       in   tvalid tready tdata tlast   option byte, last marker, tuser = empty option
// m_       out  tvalid tready tdata tlast   byte class and lengths, tlast = option done
//
// One byte per cycle sustained while m_tready is high.
// Each byte is held in the input register, then its result in the result register around the parser.
// aresetn synchronous, active low: clears valids and parser state.
// A stall on m_tready holds the result and backs up into s_tready.
`default_nettype none

module oscore_option_parser
    import oscp_pkg::*;
#(
    parameter int unsigned MAX_OPTION_BYTES = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] option_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] is_empty
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] byte_role, [10:3] field_index, [11] valid_res, [14:12] error_code,
    // [17:15] piv_len, [18] has_kid_context, [26:19] kctx_len,
    // [27] has_kid, [35:28] kid_len, [39:36] zero
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);

    localparam int unsigned POS_W = $clog2(MAX_OPTION_BYTES + 1);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     slot_free;
    logic     advance;
    result_t  result;
    result_t  result_out;

    assign s_item  = '{option_byte: s_tdata, is_last: s_tlast, is_empty: s_tuser};
    assign advance = item_valid && slot_free;

    oscp_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    oscp_parse_core #(
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES),
        .POS_W            (POS_W)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    oscp_output_stage u_output (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result     (result),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .slot_free  (slot_free),
        .result_out (result_out)
    );

    assign m_tlast = result_out.done_res;
    assign m_tdata = {4'h0,
                      result_out.kid_len,
                      result_out.has_kid,
                      result_out.kctx_len,
                      result_out.has_kid_context,
                      result_out.piv_len,
                      result_out.error_code,
                      result_out.valid_res,
                      result_out.field_index,
                      result_out.byte_role};

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import oscp_pkg::*;

    localparam int OPT_MAX = 255;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] option_byte
    logic        s_tlast;
    logic        s_tuser;   // [0] is_empty
    logic        m_tvalid;
    logic        m_tready;
    // [2:0] byte_role, [10:3] field_index, [11] valid_res, [14:12] error_code,
    // [17:15] piv_len, [18] has_kid_context, [26:19] kctx_len,
    // [27] has_kid, [35:28] kid_len, [39:36] zero
    logic [39:0] m_tdata;
    logic        m_tlast;

    // parser state mirrored from the block
    logic [8:0]  opt_pos;
    logic [2:0]  piv_n;
    logic        ctx_flag;
    logic        kid_flag;
    logic [7:0]  ctx_len;
    logic [9:0]  tail_pos;
    err_t        flag_err;

    result_t     predicted_class_q[$];
    result_t     want;
    logic [7:0]  option_q[$];
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          rx_hold_left = 0;
    int          items_sent = 0;
    int          mismatches = 0;

    oscore_option_parser #(.MAX_OPTION_BYTES(OPT_MAX)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_option();
        opt_pos  = '0;
        piv_n    = '0;
        ctx_flag = 1'b0;
        kid_flag = 1'b0;
        ctx_len  = '0;
        tail_pos = '0;
        flag_err = ERR_NONE;
    endfunction

    function automatic result_t classify_byte(input logic [7:0] b, input logic is_last,
                                              input logic is_empty);
        result_t r;
        int      p;
        int      n;
        int      idx;
        int      len;
        int      kl;
        err_t    err;
        r = '0;
        if (is_empty) begin
            r.byte_role  = ROLE_NONE;
            r.done_res   = 1'b1;
            r.valid_res  = 1'b1;
            r.error_code = ERR_NONE;
            clear_option();
            return r;
        end
        p = int'(opt_pos);
        if (p == 0) begin
            piv_n    = b[2:0];
            ctx_flag = (b & FLAG_H_MASK) != 0;
            kid_flag = (b & FLAG_K_MASK) != 0;
            ctx_len  = '0;
            tail_pos = 10'(piv_n) + 10'd1;
            if ((b & FLAG_EXT_MASK) != 0)
                flag_err = ERR_EXT_BITS;
            else if (piv_n > MAX_PIV_BYTES)
                flag_err = ERR_PIV_LEN;
            else
                flag_err = ERR_NONE;
        end
        n = int'(piv_n);
        idx = 0;
        if (p == 0) begin
            r.byte_role = ROLE_FLAGS;
        end else if (p >= OPT_MAX) begin
            r.byte_role = ROLE_EXCESS;
        end else if (p < n + 1) begin
            r.byte_role = ROLE_PIV;
            idx = p - 1;
        end else if (ctx_flag && p == n + 1) begin
            ctx_len     = b;
            tail_pos    = 10'(n + 2 + int'(b));
            r.byte_role = ROLE_CTX_LEN;
        end else if (ctx_flag && p < tail_pos) begin
            r.byte_role = ROLE_CTX;
            idx = p - (n + 2);
        end else begin
            r.byte_role = kid_flag ? ROLE_KID : ROLE_EXCESS;
            idx = p - tail_pos;
        end
        r.field_index     = idx[7:0];
        r.piv_len         = piv_n;
        r.has_kid_context = ctx_flag;
        r.kctx_len        = ctx_flag ? ctx_len : 8'h00;
        r.has_kid         = kid_flag;
        r.error_code      = ERR_NONE;
        if (!is_last) begin
            if (opt_pos < OPT_MAX)
                opt_pos = opt_pos + 9'd1;
            return r;
        end
        len = p + 1;
        kl = 0;
        if (flag_err != ERR_NONE)
            err = flag_err;
        else if (len > OPT_MAX)
            err = ERR_TOO_LONG;
        else if (ctx_flag && n + 1 >= len)
            err = ERR_NO_CTX_LEN;
        else if (kid_flag) begin
            if (tail_pos > len)
                err = ERR_LEN_MISMATCH;
            else begin
                err = ERR_NONE;
                kl = len - tail_pos;
            end
        end else if (tail_pos != len)
            err = ERR_LEN_MISMATCH;
        else
            err = ERR_NONE;
        if (err != ERR_NONE)
            kl = 0;
        if (kl > 255)
            kl = 255;
        r.done_res   = 1'b1;
        r.valid_res  = (err == ERR_NONE);
        r.error_code = err;
        r.kid_len    = kl[7:0];
        clear_option();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_class_q.size() == 0) begin
                $display("%0t: transfer with nothing expected, actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = predicted_class_q.pop_front();
                check_field("byte_role", 8'(want.byte_role), 8'(m_tdata[2:0]));
                check_field("field_index", want.field_index, m_tdata[10:3]);
                check_field("done_res", 8'(want.done_res), 8'(m_tlast));
                check_field("valid_res", 8'(want.valid_res), 8'(m_tdata[11]));
                check_field("error_code", 8'(want.error_code), 8'(m_tdata[14:12]));
                check_field("piv_len", 8'(want.piv_len), 8'(m_tdata[17:15]));
                check_field("has_kid_context", 8'(want.has_kid_context), 8'(m_tdata[18]));
                check_field("kctx_len", want.kctx_len, m_tdata[26:19]);
                check_field("has_kid", 8'(want.has_kid), 8'(m_tdata[27]));
                check_field("kid_len", want.kid_len, m_tdata[35:28]);
                check_field("pad", 8'h00, {4'h0, m_tdata[39:36]});
            end
        end
    end

    // hold off the result channel while a stretch is requested
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic is_last, input logic is_empty);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        s_tuser  <= is_empty;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted_class_q.push_back(classify_byte(b, is_last, is_empty));
        items_sent++;
        @(negedge aclk);
    endtask

    // send the queued option; an empty option replaces the byte at abort_at
    task automatic send_option_q(input int abort_at);
        for (int i = 0; i < option_q.size(); i++) begin
            if (i == abort_at) begin
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                return;
            end
            send_item(option_q[i], i == option_q.size() - 1, 1'b0);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (predicted_class_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_random_option();
        int         n;
        int         ctx;
        int         kid;
        int         pick;
        int         abort_at;
        bit         h;
        bit         k;
        logic [7:0] first;
        pick = $urandom_range(99);
        abort_at = -1;
        if (pick < 5) begin
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            return;
        end
        if (pick < 10) begin
            repeat ($urandom_range(1, 5))
                send_item(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            return;
        end
        n = $urandom_range(MAX_PIV_BYTES);
        h = 1'($urandom_range(1));
        k = 1'($urandom_range(1));
        ctx = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(4);
        kid = ($urandom_range(59) == 0) ? $urandom_range(250, 300) : $urandom_range(6);
        option_q.delete();
        option_q.push_back({3'b000, h, k, n[2:0]});
        repeat (n) option_q.push_back(8'($urandom_range(255)));
        if (h) begin
            option_q.push_back(8'(ctx));
            repeat (ctx) option_q.push_back(8'($urandom_range(255)));
        end
        if (k)
            repeat (kid) option_q.push_back(8'($urandom_range(255)));
        if (pick < 22) begin
            first = option_q[0];
            case ($urandom_range(4))
                0: first[7:5] = 3'($urandom_range(1, 7));
                1: first[2:0] = 3'($urandom_range(6, 7));
                2: if (option_q.size() > 1) option_q.pop_back();
                3: repeat ($urandom_range(1, 4)) option_q.push_back(8'($urandom_range(255)));
                default: first[4] = ~first[4];
            endcase
            option_q[0] = first;
        end
        if ($urandom_range(29) == 0)
            abort_at = $urandom_range(1, option_q.size());
        send_option_q(abort_at);
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_item(8'hff, 1'b1, 1'b1);
        option_q = '{8'h00};
        send_option_q(-1);
        option_q = '{8'h0d, 8'h00, 8'hff, 8'h55, 8'haa, 8'h80, 8'h7f};
        send_option_q(-1);
        option_q = '{8'h19, 8'h01, 8'h02, 8'hfe, 8'h01, 8'h42};
        send_option_q(-1);
        option_q = '{8'he0};
        send_option_q(-1);
        option_q = '{8'h07};
        send_option_q(-1);
        option_q = '{8'h10};
        send_option_q(-1);
        option_q = '{8'h02, 8'h11};
        send_option_q(-1);
        option_q = '{8'h00, 8'h33};
        send_option_q(-1);
        option_q = '{8'h08, 8'h44, 8'h00};
        send_option_q(2);
        wait_idle();
    endtask

    task automatic test_too_long();
        option_q = '{8'h18, 8'hff};
        repeat (258) option_q.push_back(8'($urandom_range(255)));
        send_option_q(-1);
        option_q = '{8'he7};
        repeat (255) option_q.push_back(8'($urandom_range(255)));
        send_option_q(-1);
        wait_idle();
    endtask

    task automatic test_back_pressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        @(posedge aclk);
        rx_hold_left = 80;
        @(negedge aclk);
        repeat (12) send_random_option();
        wait_idle();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        int target;
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
        target = items_sent + count;
        while (items_sent < target)
            send_random_option();
        wait_idle();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        clear_option();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_too_long();
        test_back_pressure();
        test_random(0, 0, 350);
        test_random(84, 0, 300);
        test_random(0, 84, 300);
        test_random(8, 8, 300);
        test_random(0, 0, 50);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
